>>> hw/rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a consequent in the same cycle as its antecedent.
`define ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks a consequent in the cycle after its antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/mp2d_pkg.sv
package mp2d_pkg;

    localparam int CFG_DATA_W  = 11;
    localparam int CFG_INDEX_W = 3;

    localparam int ROWS_W   = 11;
    localparam int COLS_W   = 8;
    localparam int KERNEL_W = 4;
    localparam int STRIDE_W = 4;

    localparam logic [ROWS_W-1:0]   ROWS_RESET   = 11'd32;
    localparam logic [COLS_W-1:0]   COLS_RESET   = 8'd32;
    localparam logic [KERNEL_W-1:0] KERNEL_RESET = 4'd2;
    localparam logic [STRIDE_W-1:0] STRIDE_RESET = 4'd2;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_PLANE_ROWS  = 3'd0,
        CFG_PLANE_COLS  = 3'd1,
        CFG_KERNEL_ROWS = 3'd2,
        CFG_KERNEL_COLS = 3'd3,
        CFG_STRIDE_ROWS = 3'd4,
        CFG_STRIDE_COLS = 3'd5
    } cfg_index_t;

endpackage

>>> hw/rtl/mp2d_ram.sv
module mp2d_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> hw/rtl/max_pooling_2d_window_top.sv
// A sample that closes no window leaves the block idle and ready for the next sample.
// A sample that closes a window keeps the block busy: one line-store read per window
// sample through the single RAM read port, then a final compare and a push.
// A result is registered in the push state, after the reads and the final compare; a held
// result stalls the push, and so the next request, for as long as the result is stalled.
// Reset (rst_n, asynchronous, active low) restores the register defaults and the plane
// position; the line store is not cleared and needs no clearing pass.
`include "assert_macros.svh"

module max_pooling_2d_window_top
    import mp2d_pkg::*;
#(
    parameter int MAX_COLS     = 128,
    parameter int MAX_ROWS     = 1024,
    parameter int MAX_KERNEL   = 8,
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [CFG_INDEX_W-1:0]         cfg_index,
    input  logic [CFG_DATA_W-1:0]          cfg_data,
    input  logic                           sample_valid,
    output logic                           sample_stall,
    input  logic signed [SAMPLE_WIDTH-1:0] sample,
    output logic                           result_valid,
    input  logic                           result_stall,
    output logic signed [SAMPLE_WIDTH-1:0] max_value,
    output logic                           plane_done
);

    localparam int DEPTH = MAX_KERNEL * MAX_COLS;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(MAX_COLS);
    localparam int CNW   = $clog2(MAX_COLS + 1);
    localparam int RW    = $clog2(MAX_ROWS);
    localparam int RNW   = $clog2(MAX_ROWS + 1);
    localparam int KW    = $clog2(MAX_KERNEL);
    localparam int KNW   = $clog2(MAX_KERNEL + 1);
    localparam int CMPW  = ((RNW > CNW) ? RNW : CNW) + STRIDE_W + 1;

    localparam logic signed [SAMPLE_WIDTH-1:0] MOST_NEGATIVE =
        {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_LAST,
        S_PUSH
    } state_t;

    state_t                          state_reg,      state_next;
    logic [ROWS_W-1:0]               rows_cfg_reg,   rows_cfg_next;
    logic [COLS_W-1:0]               cols_cfg_reg,   cols_cfg_next;
    logic [KERNEL_W-1:0]             kr_cfg_reg,     kr_cfg_next;
    logic [KERNEL_W-1:0]             kc_cfg_reg,     kc_cfg_next;
    logic [STRIDE_W-1:0]             sr_cfg_reg,     sr_cfg_next;
    logic [STRIDE_W-1:0]             sc_cfg_reg,     sc_cfg_next;
    logic [RW-1:0]                   row_reg,        row_next;
    logic [CW-1:0]                   col_reg,        col_next;
    logic [KW-1:0]                   slot_reg,       slot_next;
    logic [STRIDE_W-1:0]             row_ph_reg,     row_ph_next;
    logic [STRIDE_W-1:0]             col_ph_reg,     col_ph_next;
    logic [CW-1:0]                   win_col_reg,    win_col_next;
    logic [KW-1:0]                   rd_slot_reg,    rd_slot_next;
    logic [CW-1:0]                   rd_col_reg,     rd_col_next;
    logic [KW-1:0]                   i_reg,          i_next;
    logic [KW-1:0]                   j_reg,          j_next;
    logic                            rd_pend_reg,    rd_pend_next;
    logic signed [SAMPLE_WIDTH-1:0]  best_reg,       best_next;
    logic                            last_reg,       last_next;
    logic                            out_valid_reg,  out_valid_next;
    logic signed [SAMPLE_WIDTH-1:0]  out_max_reg,    out_max_next;
    logic                            out_done_reg,   out_done_next;

    logic [RNW-1:0]                  rows_eff;
    logic [CNW-1:0]                  cols_eff;
    logic [KNW-1:0]                  kr_eff;
    logic [KNW-1:0]                  kc_eff;
    logic [STRIDE_W-1:0]             sr_eff;
    logic [STRIDE_W-1:0]             sc_eff;

    logic                            accept;
    logic                            win_hit;
    logic                            win_last;
    logic                            col_wrap;
    logic                            row_wrap;
    logic [CW-1:0]                   win_col;
    logic [KW:0]                     slot_sum;
    logic [KW-1:0]                   start_slot;
    logic                            last_j;
    logic                            last_i;
    logic                            out_free;

    logic                            ram_we;
    logic [AW-1:0]                   ram_waddr;
    logic [AW-1:0]                   ram_raddr;
    logic [SAMPLE_WIDTH-1:0]         ram_rdata;
    logic signed [SAMPLE_WIDTH-1:0]  rd_value;

    always_comb
    begin
        if (rows_cfg_reg == '0)
            rows_eff = RNW'(1);
        else if (32'(rows_cfg_reg) > 32'(MAX_ROWS))
            rows_eff = RNW'(MAX_ROWS);
        else
            rows_eff = RNW'(rows_cfg_reg);

        if (cols_cfg_reg == '0)
            cols_eff = CNW'(1);
        else if (32'(cols_cfg_reg) > 32'(MAX_COLS))
            cols_eff = CNW'(MAX_COLS);
        else
            cols_eff = CNW'(cols_cfg_reg);

        if (kr_cfg_reg == '0)
            kr_eff = KNW'(1);
        else if (32'(kr_cfg_reg) > 32'(MAX_KERNEL))
            kr_eff = KNW'(MAX_KERNEL);
        else
            kr_eff = KNW'(kr_cfg_reg);

        if (kc_cfg_reg == '0)
            kc_eff = KNW'(1);
        else if (32'(kc_cfg_reg) > 32'(MAX_KERNEL))
            kc_eff = KNW'(MAX_KERNEL);
        else
            kc_eff = KNW'(kc_cfg_reg);

        sr_eff = (sr_cfg_reg == '0) ? STRIDE_W'(1) : sr_cfg_reg;
        sc_eff = (sc_cfg_reg == '0) ? STRIDE_W'(1) : sc_cfg_reg;
    end

    assign accept   = sample_valid && !sample_stall;
    assign out_free = !out_valid_reg || !result_stall;

    assign col_wrap = (CMPW'(col_reg) + CMPW'(1)) >= CMPW'(cols_eff);
    assign row_wrap = (CMPW'(row_reg) + CMPW'(1)) >= CMPW'(rows_eff);

    assign win_hit = ((CMPW'(row_reg) + CMPW'(1)) >= CMPW'(kr_eff))
                  && ((CMPW'(col_reg) + CMPW'(1)) >= CMPW'(kc_eff))
                  && (CMPW'(kr_eff) <= CMPW'(rows_eff))
                  && (CMPW'(kc_eff) <= CMPW'(cols_eff))
                  && (row_ph_reg == '0)
                  && (col_ph_reg == '0);

    assign win_last = ((CMPW'(row_reg) + CMPW'(sr_eff)) >= CMPW'(rows_eff))
                   && ((CMPW'(col_reg) + CMPW'(sc_eff)) >= CMPW'(cols_eff));

    assign win_col  = CW'(CMPW'(col_reg) + CMPW'(1) - CMPW'(kc_eff));

    assign slot_sum = (KW+1)'(slot_reg) + (KW+1)'(MAX_KERNEL)
                    - (KW+1)'(kr_eff) + (KW+1)'(1);
    assign start_slot = (slot_sum >= (KW+1)'(MAX_KERNEL))
                      ? KW'(slot_sum - (KW+1)'(MAX_KERNEL)) : KW'(slot_sum);

    assign last_j = (KNW'(j_reg) + KNW'(1)) == kc_eff;
    assign last_i = (KNW'(i_reg) + KNW'(1)) == kr_eff;

    assign ram_we    = accept;
    assign ram_waddr = AW'(slot_reg) * AW'(MAX_COLS) + AW'(col_reg);
    assign ram_raddr = AW'(rd_slot_reg) * AW'(MAX_COLS) + AW'(rd_col_reg);
    assign rd_value  = $signed(ram_rdata);

    always_comb
    begin
        state_next     = state_reg;
        rows_cfg_next  = rows_cfg_reg;
        cols_cfg_next  = cols_cfg_reg;
        kr_cfg_next    = kr_cfg_reg;
        kc_cfg_next    = kc_cfg_reg;
        sr_cfg_next    = sr_cfg_reg;
        sc_cfg_next    = sc_cfg_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        slot_next      = slot_reg;
        row_ph_next    = row_ph_reg;
        col_ph_next    = col_ph_reg;
        win_col_next   = win_col_reg;
        rd_slot_next   = rd_slot_reg;
        rd_col_next    = rd_col_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        rd_pend_next   = 1'b0;
        best_next      = best_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg && result_stall;
        out_max_next   = out_max_reg;
        out_done_next  = out_done_reg;

        if (rd_pend_reg && (rd_value > best_reg))
        begin
            best_next = rd_value;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (col_wrap)
                    begin
                        col_next    = '0;
                        col_ph_next = '0;
                        if (row_wrap)
                        begin
                            row_next    = '0;
                            slot_next   = '0;
                            row_ph_next = '0;
                        end
                        else
                        begin
                            row_next  = row_reg + RW'(1);
                            slot_next = (slot_reg == KW'(MAX_KERNEL - 1))
                                      ? '0 : slot_reg + KW'(1);
                            if ((CMPW'(row_reg) + CMPW'(2)) == CMPW'(kr_eff))
                                row_ph_next = '0;
                            else if (row_ph_reg == sr_eff - STRIDE_W'(1))
                                row_ph_next = '0;
                            else
                                row_ph_next = row_ph_reg + STRIDE_W'(1);
                        end
                    end
                    else
                    begin
                        col_next = col_reg + CW'(1);
                        if ((CMPW'(col_reg) + CMPW'(2)) == CMPW'(kc_eff))
                            col_ph_next = '0;
                        else if (col_ph_reg == sc_eff - STRIDE_W'(1))
                            col_ph_next = '0;
                        else
                            col_ph_next = col_ph_reg + STRIDE_W'(1);
                    end

                    best_next    = MOST_NEGATIVE;
                    last_next    = win_last;
                    win_col_next = win_col;
                    rd_slot_next = start_slot;
                    rd_col_next  = win_col;
                    i_next       = '0;
                    j_next       = '0;
                    if (win_hit)
                    begin
                        state_next = S_READ;
                    end
                end
            end

            S_READ:
            begin
                rd_pend_next = 1'b1;
                if (last_j)
                begin
                    j_next       = '0;
                    rd_col_next  = win_col_reg;
                    i_next       = i_reg + KW'(1);
                    rd_slot_next = (rd_slot_reg == KW'(MAX_KERNEL - 1))
                                 ? '0 : rd_slot_reg + KW'(1);
                    if (last_i)
                    begin
                        state_next = S_LAST;
                    end
                end
                else
                begin
                    j_next      = j_reg + KW'(1);
                    rd_col_next = rd_col_reg + CW'(1);
                end
            end

            S_LAST:
            begin
                state_next = S_PUSH;
            end

            S_PUSH:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_max_next   = best_reg;
                    out_done_next  = last_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cfg_we)
        begin
            case (cfg_index)
                CFG_PLANE_ROWS:  rows_cfg_next = cfg_data[ROWS_W-1:0];
                CFG_PLANE_COLS:  cols_cfg_next = cfg_data[COLS_W-1:0];
                CFG_KERNEL_ROWS: kr_cfg_next   = cfg_data[KERNEL_W-1:0];
                CFG_KERNEL_COLS: kc_cfg_next   = cfg_data[KERNEL_W-1:0];
                CFG_STRIDE_ROWS: sr_cfg_next   = cfg_data[STRIDE_W-1:0];
                CFG_STRIDE_COLS: sc_cfg_next   = cfg_data[STRIDE_W-1:0];
                default:         ;
            endcase
            case (cfg_index)
                CFG_PLANE_ROWS, CFG_PLANE_COLS, CFG_KERNEL_ROWS,
                CFG_KERNEL_COLS, CFG_STRIDE_ROWS, CFG_STRIDE_COLS:
                begin
                    row_next    = '0;
                    col_next    = '0;
                    slot_next   = '0;
                    row_ph_next = '0;
                    col_ph_next = '0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rows_cfg_reg  <= ROWS_RESET;
            cols_cfg_reg  <= COLS_RESET;
            kr_cfg_reg    <= KERNEL_RESET;
            kc_cfg_reg    <= KERNEL_RESET;
            sr_cfg_reg    <= STRIDE_RESET;
            sc_cfg_reg    <= STRIDE_RESET;
            row_reg       <= '0;
            col_reg       <= '0;
            slot_reg      <= '0;
            row_ph_reg    <= '0;
            col_ph_reg    <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            rd_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rows_cfg_reg  <= rows_cfg_next;
            cols_cfg_reg  <= cols_cfg_next;
            kr_cfg_reg    <= kr_cfg_next;
            kc_cfg_reg    <= kc_cfg_next;
            sr_cfg_reg    <= sr_cfg_next;
            sc_cfg_reg    <= sc_cfg_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            slot_reg      <= slot_next;
            row_ph_reg    <= row_ph_next;
            col_ph_reg    <= col_ph_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            rd_pend_reg   <= rd_pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        win_col_reg <= win_col_next;
        rd_slot_reg <= rd_slot_next;
        rd_col_reg  <= rd_col_next;
        best_reg    <= best_next;
        last_reg    <= last_next;
        out_max_reg <= out_max_next;
        out_done_reg <= out_done_next;
    end

    mp2d_ram #(
        .WIDTH (SAMPLE_WIDTH),
        .DEPTH (DEPTH)
    ) u_line_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (sample),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign sample_stall = (state_reg != S_IDLE);
    assign result_valid = out_valid_reg;
    assign max_value    = out_max_reg;
    assign plane_done   = out_done_reg;

    `ASSERT_NEXT(a_hit_starts_read, accept && win_hit, state_reg == S_READ, "Window hit did not start the read sequence.")
    `ASSERT_NEXT(a_push_holds, (state_reg == S_PUSH) && out_valid_reg && result_stall, state_reg == S_PUSH, "A pending result was overwritten.")
    `ASSERT_NOW(a_col_in_plane, 1'b1, CMPW'(col_reg) < CMPW'(cols_eff), "Column position left the plane.")
    `ASSERT_NOW(a_read_bounds, state_reg == S_READ, (KNW'(i_reg) < kr_eff) && (KNW'(j_reg) < kc_eff), "Window read index out of range.")

endmodule

>>> test/tb.sv
module tb;
    import mp2d_pkg::*;

    localparam int MAX_COLS     = 128;
    localparam int MAX_ROWS     = 1024;
    localparam int MAX_KERNEL   = 8;
    localparam int SAMPLE_WIDTH = 16;
    localparam int STORE_DEPTH  = MAX_KERNEL * MAX_COLS;
    localparam int DRAIN_CYCLES = MAX_KERNEL * MAX_KERNEL + 16;
    localparam int RANDOM_ITEMS = 1050;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int REG_COUNT    = 6;
    localparam int REG_WIDTH [REG_COUNT] = '{ROWS_W, COLS_W, KERNEL_W, KERNEL_W, STRIDE_W,
                                             STRIDE_W};
    localparam logic [CFG_INDEX_W-1:0] CFG_INDEX_UNUSED = '1;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] max_value;
        logic                           plane_done;
    } window_t;

    typedef struct packed {
        bit                             is_write;
        logic [CFG_INDEX_W-1:0]         index;
        logic [CFG_DATA_W-1:0]          data;
        logic signed [SAMPLE_WIDTH-1:0] value;
        bit                             typed;
        bit                             has_result;
        logic signed [SAMPLE_WIDTH-1:0] exp_max;
        bit                             exp_done;
    } step_t;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_RANDOM,
        STALL_SOLID
    } stall_mode_t;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0]         cfg_index = '0;
    logic [CFG_DATA_W-1:0]          cfg_data = '0;
    logic                           sample_valid = 1'b0;
    logic                           sample_stall;
    logic signed [SAMPLE_WIDTH-1:0] sample = '0;
    logic                           result_valid;
    logic                           result_stall = 1'b0;
    logic signed [SAMPLE_WIDTH-1:0] max_value;
    logic                           plane_done;

    logic [CFG_DATA_W-1:0]          cfg_shadow [REG_COUNT];
    logic signed [SAMPLE_WIDTH-1:0] line_copy [STORE_DEPTH];
    int                             next_row = 0;
    int                             next_col = 0;

    window_t     pending_windows [$];
    int          mismatches = 0;
    int          cycle_count = 0;
    int          burst_left = 0;
    int          random_items = 0;
    stall_mode_t stall_mode = STALL_NONE;
    int          stall_run = 0;

    step_t directed_steps [37] = '{
        '{1'b0, '0, '0, 16'sh1234, 1'b1, 1'b0, '0, 1'b0},
        '{1'b0, '0, '0, 16'sh8000, 1'b1, 1'b0, '0, 1'b0},
        '{1'b1, CFG_PLANE_ROWS, 11'd0, '0, 1'b0, 1'b0, '0, 1'b0},
        '{1'b1, CFG_PLANE_COLS, 11'd0, '0, 1'b0, 1'b0, '0, 1'b0},
        '{1'b1, CFG_KERNEL_ROWS, 11'd1, '0, 1'b0, 1'b0, '0, 1'b0},
        '{1'b1, CFG_KERNEL_COLS, 11'd0, '0, 1'b0, 1'b0, '0, 1'b0},
        '{1'b1, CFG_STRIDE_ROWS, 11'd0, '0, 1'b0, 1'b0, '0, 1'b0},
        '{1'b1, CFG_STRIDE_COLS, 11'd1, '0, 1'b0, 1'b0, '0, 1'b0},
        '{1'b0, '0, '0, 16'sh7FFF, 1'b1, 1'b1, 16'sh7FFF, 1'b1},
        '{1'b0, '0, '0, 16'sh8000, 1'b1, 1'b1, 16'sh8000, 1'b1},
        '{1'b0, '0, '0, 16'sh0000, 1'b1, 1'b1, 16'sh0000, 1'b1},
        '{1'b0, '0, '0, 16'shFFFF, 1'b1, 1'b1, 16'shFFFF, 1'b1},
        '{1'b0, '0, '0, 16'sh5555, 1'b1, 1'b1, 16'sh5555, 1'b1},
        '{1'b0, '0, '0, 16'shAAAA, 1'b1, 1'b1, 16'shAAAA, 1'b1},
        '{1'b1, CFG_KERNEL_ROWS, 11'd2, '0, 1'b0, 1'b0, '0, 1'b0},
        '{1'b0, '0, '0, 16'sh0100, 1'b1, 1'b0, '0, 1'b0},
        '{1'b1, CFG_KERNEL_ROWS, 11'd1, '0, 1'b0, 1'b0, '0, 1'b0},
        '{1'b1, CFG_KERNEL_COLS, 11'd2, '0, 1'b0, 1'b0, '0, 1'b0},
        '{1'b0, '0, '0, 16'sh0200, 1'b1, 1'b0, '0, 1'b0},
        '{1'b1, CFG_PLANE_ROWS, 11'd2, '0, 1'b0, 1'b0, '0, 1'b0},
        '{1'b1, CFG_PLANE_COLS, 11'd2, '0, 1'b0, 1'b0, '0, 1'b0},
        '{1'b1, CFG_KERNEL_ROWS, 11'd2, '0, 1'b0, 1'b0, '0, 1'b0},
        '{1'b0, '0, '0, 16'sh8000, 1'b1, 1'b0, '0, 1'b0},
        '{1'b0, '0, '0, 16'shFFFF, 1'b1, 1'b0, '0, 1'b0},
        '{1'b0, '0, '0, 16'sh8001, 1'b1, 1'b0, '0, 1'b0},
        '{1'b0, '0, '0, 16'shFFFE, 1'b1, 1'b1, 16'shFFFF, 1'b1},
        '{1'b1, CFG_PLANE_ROWS, 11'h7FF, '0, 1'b0, 1'b0, '0, 1'b0},
        '{1'b1, CFG_PLANE_COLS, 11'h7FF, '0, 1'b0, 1'b0, '0, 1'b0},
        '{1'b1, CFG_KERNEL_ROWS, 11'd15, '0, 1'b0, 1'b0, '0, 1'b0},
        '{1'b1, CFG_KERNEL_COLS, 11'd9, '0, 1'b0, 1'b0, '0, 1'b0},
        '{1'b1, CFG_STRIDE_ROWS, 11'd15, '0, 1'b0, 1'b0, '0, 1'b0},
        '{1'b1, CFG_STRIDE_COLS, 11'd8, '0, 1'b0, 1'b0, '0, 1'b0},
        '{1'b0, '0, '0, 16'sh0F0F, 1'b0, 1'b0, '0, 1'b0},
        '{1'b0, '0, '0, 16'shF0F0, 1'b0, 1'b0, '0, 1'b0},
        '{1'b0, '0, '0, 16'sh7FFE, 1'b0, 1'b0, '0, 1'b0},
        '{1'b1, CFG_INDEX_UNUSED, 11'h7FF, '0, 1'b0, 1'b0, '0, 1'b0},
        '{1'b0, '0, '0, 16'sh0001, 1'b0, 1'b0, '0, 1'b0}
    };

    max_pooling_2d_window_top #(
        .MAX_COLS     (MAX_COLS),
        .MAX_ROWS     (MAX_ROWS),
        .MAX_KERNEL   (MAX_KERNEL),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .max_value    (max_value),
        .plane_done   (plane_done)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic int clamp_size(input int value, input int limit);
        if (value == 0)
            return 1;
        if (value > limit)
            return limit;
        return value;
    endfunction

    task automatic pool_sample(input logic signed [SAMPLE_WIDTH-1:0] value,
                               output bit produced, output window_t win);
        int rows, cols, kr, kc, sr, sc, r, c, orow, ocol, i, j;
        logic signed [SAMPLE_WIDTH-1:0] best;
        logic signed [SAMPLE_WIDTH-1:0] entry;
        rows = clamp_size(int'(cfg_shadow[CFG_PLANE_ROWS]), MAX_ROWS);
        cols = clamp_size(int'(cfg_shadow[CFG_PLANE_COLS]), MAX_COLS);
        kr = clamp_size(int'(cfg_shadow[CFG_KERNEL_ROWS]), MAX_KERNEL);
        kc = clamp_size(int'(cfg_shadow[CFG_KERNEL_COLS]), MAX_KERNEL);
        sr = clamp_size(int'(cfg_shadow[CFG_STRIDE_ROWS]), 255);
        sc = clamp_size(int'(cfg_shadow[CFG_STRIDE_COLS]), 255);
        produced = 1'b0;
        win = '0;
        r = (next_row >= rows) ? 0 : next_row;
        c = (next_col >= cols) ? 0 : next_col;
        line_copy[((r % MAX_KERNEL) * MAX_COLS + c) % STORE_DEPTH] = value;
        if (r + 1 >= kr && c + 1 >= kc && kr <= rows && kc <= cols)
        begin
            orow = r + 1 - kr;
            ocol = c + 1 - kc;
            if (orow % sr == 0 && ocol % sc == 0)
            begin
                best = line_copy[((orow % MAX_KERNEL) * MAX_COLS + ocol) % STORE_DEPTH];
                for (i = 0; i < kr; i++)
                begin
                    for (j = 0; j < kc; j++)
                    begin
                        entry = line_copy[(((orow + i) % MAX_KERNEL) * MAX_COLS + ocol + j)
                                          % STORE_DEPTH];
                        if (entry > best)
                            best = entry;
                    end
                end
                win.max_value = best;
                win.plane_done = (orow == ((rows - kr) / sr) * sr) &&
                                 (ocol == ((cols - kc) / sc) * sc);
                produced = 1'b1;
            end
        end
        c++;
        if (c >= cols)
        begin
            c = 0;
            r++;
            if (r >= rows)
                r = 0;
        end
        next_row = r;
        next_col = c;
    endtask

    task automatic write_register(input logic [CFG_INDEX_W-1:0] index,
                                  input logic [CFG_DATA_W-1:0] data);
        sample_valid <= 1'b0;
        while (pending_windows.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= index;
        cfg_data <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (index < REG_COUNT)
        begin
            cfg_shadow[index] = CFG_DATA_W'(data & ((1 << REG_WIDTH[index]) - 1));
            next_row = 0;
            next_col = 0;
        end
    endtask

    task automatic configure_plane(input int rows, input int cols, input int kr, input int kc,
                                   input int sr, input int sc);
        write_register(CFG_PLANE_ROWS, CFG_DATA_W'(rows));
        write_register(CFG_PLANE_COLS, CFG_DATA_W'(cols));
        write_register(CFG_KERNEL_ROWS, CFG_DATA_W'(kr));
        write_register(CFG_KERNEL_COLS, CFG_DATA_W'(kc));
        write_register(CFG_STRIDE_ROWS, CFG_DATA_W'(sr));
        write_register(CFG_STRIDE_COLS, CFG_DATA_W'(sc));
    endtask

    task automatic send_request(input logic signed [SAMPLE_WIDTH-1:0] value, input bit typed,
                                input bit has_result, input window_t typed_win);
        int gap;
        bit produced;
        window_t win;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                sample_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        sample_valid <= 1'b1;
        sample <= value;
        do
            @(posedge clk);
        while (sample_stall);
        pool_sample(value, produced, win);
        if (typed)
        begin
            if (has_result)
                pending_windows.push_back(typed_win);
        end
        else if (produced)
            pending_windows.push_back(win);
    endtask

    task automatic send_stream(input int count);
        logic signed [SAMPLE_WIDTH-1:0] value;
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(63) == 0)
            begin
                sample_valid <= 1'b0;
                do
                    @(posedge clk);
                while (pending_windows.size() != 0);
            end
            case ($urandom_range(9))
                0: value = {1'b0, {(SAMPLE_WIDTH - 1){1'b1}}};
                1: value = {1'b1, {(SAMPLE_WIDTH - 1){1'b0}}};
                default: value = SAMPLE_WIDTH'($urandom);
            endcase
            send_request(value, 1'b0, 1'b0, '0);
            random_items++;
        end
    endtask

    function automatic int pick_step(input int common_high);
        if ($urandom_range(7) == 0)
            return $urandom_range(15);
        return $urandom_range(1, common_high);
    endfunction

    task report_mismatch(input string line);
        $display("%s", line);
        mismatches++;
    endtask

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("tb NOT OK");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (stall_run == 0)
        begin
            stall_mode <= stall_mode_t'($urandom_range(2));
            stall_run <= $urandom_range(4, 40);
            result_stall <= 1'b0;
        end
        else
        begin
            stall_run <= stall_run - 1;
            case (stall_mode)
                STALL_RANDOM: result_stall <= ($urandom_range(2) == 0);
                STALL_SOLID: result_stall <= 1'b1;
                default: result_stall <= 1'b0;
            endcase
        end
    end

    always @(posedge clk)
    begin
        window_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_windows.size() == 0)
                report_mismatch($sformatf("unexpected window max %0d done %0b at cycle %0d",
                                          max_value, plane_done, cycle_count));
            else
            begin
                want = pending_windows.pop_front();
                if (max_value !== want.max_value)
                    report_mismatch($sformatf("max_value %0d, want %0d at cycle %0d",
                                              max_value, want.max_value, cycle_count));
                if (plane_done !== want.plane_done)
                    report_mismatch($sformatf("plane_done %0b, want %0b at cycle %0d",
                                              plane_done, want.plane_done, cycle_count));
            end
        end
    end

    initial
    begin
        int rows, cols, planes;
        cfg_shadow[CFG_PLANE_ROWS] = CFG_DATA_W'(ROWS_RESET);
        cfg_shadow[CFG_PLANE_COLS] = CFG_DATA_W'(COLS_RESET);
        cfg_shadow[CFG_KERNEL_ROWS] = CFG_DATA_W'(KERNEL_RESET);
        cfg_shadow[CFG_KERNEL_COLS] = CFG_DATA_W'(KERNEL_RESET);
        cfg_shadow[CFG_STRIDE_ROWS] = CFG_DATA_W'(STRIDE_RESET);
        cfg_shadow[CFG_STRIDE_COLS] = CFG_DATA_W'(STRIDE_RESET);
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_steps[k])
        begin
            if (directed_steps[k].is_write)
                write_register(directed_steps[k].index, directed_steps[k].data);
            else
                send_request(directed_steps[k].value, directed_steps[k].typed,
                             directed_steps[k].has_result,
                             {directed_steps[k].exp_max, directed_steps[k].exp_done});
        end

        configure_plane(MAX_KERNEL, MAX_KERNEL, MAX_KERNEL, MAX_KERNEL, 1, 1);
        send_stream(MAX_KERNEL * MAX_KERNEL);
        configure_plane(1, MAX_COLS, 1, MAX_KERNEL, 1, 1);
        send_stream(MAX_COLS);
        configure_plane(MAX_ROWS, 1, 3, 1, 5, 1);
        send_stream(160);
        configure_plane(9, 10, MAX_KERNEL, MAX_KERNEL, 1, 1);
        send_stream(180);
        configure_plane(12, 17, 3, 2, MAX_KERNEL, MAX_KERNEL);
        send_stream(204);

        while (random_items < RANDOM_ITEMS)
        begin
            rows = ($urandom_range(9) == 0) ? $urandom_range(2) : $urandom_range(1, 12);
            cols = ($urandom_range(9) == 0) ? $urandom_range(2) : $urandom_range(1, 20);
            configure_plane(rows, cols, pick_step(4), pick_step(4), pick_step(3),
                            pick_step(3));
            planes = clamp_size(rows, MAX_ROWS) * clamp_size(cols, MAX_COLS);
            if ($urandom_range(4) == 0)
                send_stream($urandom_range(1, 2 * planes));
            else
                send_stream(clamp_size(planes * $urandom_range(1, 3), 300));
        end

        sample_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_windows.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end
endmodule

>>> filelist.f
+incdir+hw/rtl
hw/rtl/mp2d_pkg.sv
hw/rtl/mp2d_ram.sv
hw/rtl/max_pooling_2d_window_top.sv
test/tb.sv
